/* sv/npm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npm_pkg
// Shared types and constants for the nearest point match unit.
// ----------------------------------------------------------------------------
package npm_pkg;

    // Command codes on the op input
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    // Fixed field widths
    localparam int THR_W     = 16;
    localparam int IN_W      = 16;
    localparam int QN_W      = 16;
    localparam int IDX_OUT_W = 11;
    localparam int DSQ_OUT_W = 34;

    // Initial best distance of a scan (1000000 squared)
    localparam int              CAP_W    = 40;
    localparam logic [CAP_W-1:0] DIST_CAP = 40'd1000000000000;

endpackage

/* sv/npm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module npm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* sv/nearest_point_match_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_match_unit
// Brute-force nearest neighbor search over a stored set of 3D points.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a clock edge with start high and busy low.
//   op clear empties the point set and zeroes the query counter; op append
//   stores the point at the next free slot (dropped when full). Both leave
//   busy low. op query raises busy and scans every stored point, one RAM
//   read per cycle, through a four-stage distance pipeline (abs difference,
//   square, sum, compare). The result is registered once the scan has ended
//   and the pipeline has drained, and is marked by o_result_valid for
//   exactly one cycle; the receiver cannot stall it. busy falls in the same
//   cycle, so the next command may be taken while the result is on the
//   ports. The single RAM read port sets the scan to one point per cycle.
//   The threshold register is to be written through i_cfg_we / i_cfg_wdata
//   only while the unit is idle; the block itself does not enforce this.
//   Reset clears the point count, query counter, threshold and control
//   state; the point RAM is not cleared, since only entries below the count
//   are read.
// ----------------------------------------------------------------------------
module nearest_point_match_unit #(
    parameter int CAPACITY   = 2048,
    parameter int COORD_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_op,
    input  logic signed [npm_pkg::IN_W-1:0]  i_coord_x,
    input  logic signed [npm_pkg::IN_W-1:0]  i_coord_y,
    input  logic signed [npm_pkg::IN_W-1:0]  i_coord_z,
    input  logic                             i_cfg_we,
    input  logic [npm_pkg::THR_W-1:0]        i_cfg_wdata,
    output logic                             o_result_valid,
    output logic                             o_matched,
    output logic [npm_pkg::IDX_OUT_W-1:0]    o_nearest_index,
    output logic [npm_pkg::DSQ_OUT_W-1:0]    o_nearest_dist_sq,
    output logic [npm_pkg::QN_W-1:0]         o_query_number
);

    localparam int CB      = COORD_BITS;
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int PT_W    = 3 * CB;
    localparam int EXT_W   = (CB > npm_pkg::IN_W) ? CB : npm_pkg::IN_W;
    localparam int SQ_W    = 2 * (CB + 1);
    localparam int DIST_W  = SQ_W + 2;
    localparam int BEST_W  = (DIST_W > npm_pkg::CAP_W) ? DIST_W : npm_pkg::CAP_W;
    localparam int IDXX_W  = (IDX_W > npm_pkg::IDX_OUT_W) ? IDX_W : npm_pkg::IDX_OUT_W;
    localparam int THSQ_W  = 2 * npm_pkg::THR_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    // Control state
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count;
    logic [npm_pkg::QN_W-1:0]  r_qcnt;
    logic [npm_pkg::THR_W-1:0] r_thr;
    logic [IDX_W-1:0]          r_rd_addr;
    logic                      r_v1, r_v2, r_v3, r_v4;
    logic                      r_found;

    // Payload state
    logic [THSQ_W-1:0]         r_thr_sq;
    logic [CB-1:0]             r_qx, r_qy, r_qz;
    logic [npm_pkg::QN_W-1:0]  r_qnum;
    logic [IDX_W-1:0]          r_i1, r_i2, r_i3, r_i4;
    logic [CB:0]               r_ax, r_ay, r_az;
    logic [SQ_W-1:0]           r_sx, r_sy, r_sz;
    logic [DIST_W-1:0]         r_sum;
    logic [BEST_W-1:0]         r_best;
    logic [IDX_W-1:0]          r_best_idx;

    // Datapath wires
    logic                      w_accept;
    logic [EXT_W-1:0]          w_ext_x, w_ext_y, w_ext_z;
    logic [CB-1:0]             w_cx, w_cy, w_cz;
    logic                      w_we;
    logic                      w_re;
    logic [PT_W-1:0]           w_rd_data;
    logic [CB-1:0]             w_px, w_py, w_pz;
    logic signed [CB:0]        w_dx, w_dy, w_dz;
    logic [BEST_W-1:0]         w_sum_ext;
    logic                      w_last;
    logic                      w_pipe_empty;
    logic                      w_hit;
    logic [IDXX_W-1:0]         w_idx_ext;

    assign w_accept       = start && !busy;
    assign busy           = (r_state != ST_IDLE);

    // Take the low COORD_BITS of each coordinate as two's complement
    assign w_ext_x = EXT_W'($unsigned(i_coord_x));
    assign w_ext_y = EXT_W'($unsigned(i_coord_y));
    assign w_ext_z = EXT_W'($unsigned(i_coord_z));
    assign w_cx    = w_ext_x[CB-1:0];
    assign w_cy    = w_ext_y[CB-1:0];
    assign w_cz    = w_ext_z[CB-1:0];

    // Append writes the next free slot; scan reads one point per cycle
    assign w_we = w_accept && (i_op == npm_pkg::OP_APPEND) && (r_count < CNT_W'(CAPACITY));
    assign w_re = (r_state == ST_SCAN);

    npm_ram #(
        .WIDTH (PT_W),
        .DEPTH (CAPACITY)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({w_cz, w_cy, w_cx}),
        .i_re    (w_re),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rd_data)
    );

    assign w_px = w_rd_data[CB-1:0];
    assign w_py = w_rd_data[2*CB-1:CB];
    assign w_pz = w_rd_data[3*CB-1:2*CB];

    // Signed differences, one bit wider than a coordinate
    assign w_dx = $signed({w_px[CB-1], w_px}) - $signed({r_qx[CB-1], r_qx});
    assign w_dy = $signed({w_py[CB-1], w_py}) - $signed({r_qy[CB-1], r_qy});
    assign w_dz = $signed({w_pz[CB-1], w_pz}) - $signed({r_qz[CB-1], r_qz});

    assign w_sum_ext    = BEST_W'(r_sum);
    assign w_last       = (CNT_W'(r_rd_addr) == (r_count - CNT_W'(1)));
    assign w_pipe_empty = !(r_v1 || r_v2 || r_v3 || r_v4);
    assign w_hit        = r_found && (r_best < BEST_W'(r_thr_sq));
    assign w_idx_ext    = IDXX_W'(r_best_idx);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_op == npm_pkg::OP_QUERY)) begin
                    n_state = (r_count == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_pipe_empty) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, counters and registered result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= '0;
            r_qcnt         <= '0;
            r_thr          <= '0;
            r_rd_addr      <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            r_v4           <= 1'b0;
            r_found        <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            o_result_valid <= (r_state == ST_DRAIN) && w_pipe_empty;

            // Hold the threshold register
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end

            // Commands
            if (w_accept) begin
                unique case (i_op)
                    npm_pkg::OP_CLEAR: begin
                        r_count <= '0;
                        r_qcnt  <= '0;
                    end
                    npm_pkg::OP_APPEND: begin
                        if (w_we) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    npm_pkg::OP_QUERY: begin
                        r_qcnt    <= r_qcnt + npm_pkg::QN_W'(1);
                        r_rd_addr <= '0;
                        r_found   <= 1'b0;
                    end
                    default: begin
                        r_count <= r_count;
                    end
                endcase
            end

            // Advance the read address during the scan
            if (r_state == ST_SCAN) begin
                r_rd_addr <= r_rd_addr + IDX_W'(1);
            end

            // Stage valids
            r_v1 <= (r_state == ST_SCAN);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;

            // Mark a candidate found
            if (r_v4 && (w_sum_ext < r_best)) begin
                r_found <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Latch the query
        if (w_accept && (i_op == npm_pkg::OP_QUERY)) begin
            r_qx     <= w_cx;
            r_qy     <= w_cy;
            r_qz     <= w_cz;
            r_qnum   <= r_qcnt;
            r_thr_sq <= THSQ_W'(r_thr) * THSQ_W'(r_thr);
            r_best   <= BEST_W'(npm_pkg::DIST_CAP);
        end

        // Stage 1: magnitudes of the differences
        r_i1 <= r_rd_addr;
        r_i2 <= r_i1;
        r_ax <= w_dx[CB] ? $unsigned(-w_dx) : $unsigned(w_dx);
        r_ay <= w_dy[CB] ? $unsigned(-w_dy) : $unsigned(w_dy);
        r_az <= w_dz[CB] ? $unsigned(-w_dz) : $unsigned(w_dz);

        // Stage 2: squares
        r_i3 <= r_i2;
        r_sx <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sy <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_sz <= SQ_W'(r_az) * SQ_W'(r_az);

        // Stage 3: sum
        r_i4  <= r_i3;
        r_sum <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);

        // Stage 4: keep the strictly smaller distance
        if (r_v4 && (w_sum_ext < r_best)) begin
            r_best     <= w_sum_ext;
            r_best_idx <= r_i4;
        end

        // Result payload
        if ((r_state == ST_DRAIN) && w_pipe_empty) begin
            o_matched         <= w_hit;
            o_nearest_index   <= r_found ? w_idx_ext[npm_pkg::IDX_OUT_W-1:0] : '0;
            o_nearest_dist_sq <= r_found ? r_best[npm_pkg::DSQ_OUT_W-1:0] : '0;
            o_query_number    <= r_qnum;
        end
    end

endmodule
